### sv/epd_pkg.sv
// Shared types, codes and constants of the end phrase detector.
package epd_pkg;

   // One classified transcript byte as it travels from the front to the back.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_zero;
      logic       is_blank;
      logic       is_mark;
   } word_type;

   localparam int WORD_W = $bits(word_type);

   // Scan phase codes.
   localparam logic [1:0] PH_LEAD  = 2'd0;
   localparam logic [1:0] PH_MATCH = 2'd1;
   localparam logic [1:0] PH_TAIL  = 2'd2;
   localparam logic [1:0] PH_FAIL  = 2'd3;

   // Partial three-byte mark codes.
   localparam logic [2:0] MK_NONE  = 3'd0;
   localparam logic [2:0] MK_E3    = 3'd1;
   localparam logic [2:0] MK_E3_80 = 3'd2;
   localparam logic [2:0] MK_EF    = 3'd3;
   localparam logic [2:0] MK_EF_BC = 3'd4;

   // Character constants.
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_BANG      = 8'h21;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_PERIOD    = 8'h2E;
   localparam logic [7:0] CH_SEMICOLON = 8'h3B;
   localparam logic [7:0] CH_QUESTION  = 8'h3F;

   localparam logic [7:0] MARK_LEAD_A  = 8'hE3;
   localparam logic [7:0] MARK_MID_A   = 8'h80;
   localparam logic [7:0] MARK_LEAD_B  = 8'hEF;
   localparam logic [7:0] MARK_MID_B   = 8'hBC;
   localparam logic [7:0] MARK_END_81  = 8'h81;
   localparam logic [7:0] MARK_END_82  = 8'h82;
   localparam logic [7:0] MARK_END_8C  = 8'h8C;
   localparam logic [7:0] MARK_END_8E  = 8'h8E;
   localparam logic [7:0] MARK_END_9B  = 8'h9B;
   localparam logic [7:0] MARK_END_9F  = 8'h9F;

   // The phrase in UTF-8; positions past its twelve bytes hold zero.
   localparam logic [7:0] PHRASE_BYTES [0:15] = '{
      8'hE7, 8'hBB, 8'h93, 8'hE6, 8'h9D, 8'h9F, 8'hE8, 8'h81,
      8'h8A, 8'hE5, 8'hA4, 8'hA9, 8'h00, 8'h00, 8'h00, 8'h00
   };

endpackage

### sv/epd_fifo.sv
// Small register based first-in first-out queue.
module epd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### sv/epd_front.sv
// Front end: accepts transcript bytes and classifies them into words.
module epd_front import epd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_text_byte,
   output logic       req_full,
   output logic       fe_valid,
   output word_type   fe_word,
   input  logic       fe_full
);

   logic     valid_ff, valid_in;
   word_type word_ff, word_in;
   logic     accept;
   logic [7:0] b;

   assign b        = req_text_byte;
   assign req_full = valid_ff && fe_full;
   assign accept   = req_push && !req_full;
   assign fe_valid = valid_ff;
   assign fe_word  = word_ff;

   always_comb begin
      word_in.text_byte = b;
      word_in.is_zero   = (b == CH_NUL);
      word_in.is_blank  = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
      word_in.is_mark   = (b == CH_PERIOD) || (b == CH_COMMA) || (b == CH_BANG) ||
                          (b == CH_QUESTION) || (b == CH_SEMICOLON);
      if (accept) begin
         valid_in = 1'b1;
      end else if (valid_ff && !fe_full) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

endmodule

### sv/epd_back.sv
// Back end: runs the phrase and trailing-mark scan and issues verdicts.
module epd_back import epd_pkg::*; #(
   parameter int PHRASE_LENGTH = 12
) (
   input  logic     clock,
   input  logic     reset,
   input  word_type q_word,
   input  logic     q_empty,
   output logic     q_pop,
   output logic     v_push,
   output logic     v_data,
   input  logic     v_full
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] pos_ff, pos_in;
   logic [2:0] mark_ff, mark_in;
   logic [3:0] pos_next;
   logic       byte_hit;
   logic       phrase_done;
   logic [1:0] adv_phase;
   logic [1:0] tail_phase;
   logic [2:0] tail_mark;
   logic [7:0] b;

   assign b           = q_word.text_byte;
   assign q_pop       = !q_empty && !v_full;
   assign v_push      = q_pop && q_word.is_zero;
   assign v_data      = (phase_ff == PH_TAIL) && (mark_ff == MK_NONE);
   assign byte_hit    = (b == PHRASE_BYTES[pos_ff]);
   assign pos_next    = pos_ff + 4'd1;
   assign phrase_done = ({1'b0, pos_next} >= 5'(PHRASE_LENGTH)) || (pos_next == 4'd0);
   assign adv_phase   = !byte_hit ? PH_FAIL : (phrase_done ? PH_TAIL : PH_MATCH);

   always_comb begin
      tail_phase = PH_TAIL;
      tail_mark  = mark_ff;
      unique case (mark_ff)
         MK_NONE: begin
            if (q_word.is_blank || q_word.is_mark) begin
               tail_mark = MK_NONE;
            end else if (b == MARK_LEAD_A) begin
               tail_mark = MK_E3;
            end else if (b == MARK_LEAD_B) begin
               tail_mark = MK_EF;
            end else begin
               tail_phase = PH_FAIL;
            end
         end
         MK_E3: begin
            if (b == MARK_MID_A) begin
               tail_mark = MK_E3_80;
            end else begin
               tail_phase = PH_FAIL;
            end
         end
         MK_E3_80: begin
            if ((b == MARK_END_81) || (b == MARK_END_82)) begin
               tail_mark = MK_NONE;
            end else begin
               tail_phase = PH_FAIL;
            end
         end
         MK_EF: begin
            if (b == MARK_MID_B) begin
               tail_mark = MK_EF_BC;
            end else begin
               tail_phase = PH_FAIL;
            end
         end
         MK_EF_BC: begin
            if ((b == MARK_END_81) || (b == MARK_END_8C) || (b == MARK_END_8E) ||
                (b == MARK_END_9B) || (b == MARK_END_9F)) begin
               tail_mark = MK_NONE;
            end else begin
               tail_phase = PH_FAIL;
            end
         end
         default: begin
            tail_phase = PH_FAIL;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      mark_in  = mark_ff;
      if (q_pop) begin
         if (q_word.is_zero) begin
            phase_in = PH_LEAD;
            pos_in   = 4'd0;
            mark_in  = MK_NONE;
         end else begin
            unique case (phase_ff)
               PH_LEAD: begin
                  if (!q_word.is_blank) begin
                     phase_in = adv_phase;
                     pos_in   = byte_hit ? pos_next : pos_ff;
                  end
               end
               PH_MATCH: begin
                  phase_in = adv_phase;
                  pos_in   = byte_hit ? pos_next : pos_ff;
               end
               PH_TAIL: begin
                  phase_in = tail_phase;
                  mark_in  = tail_mark;
               end
               default: begin
                  phase_in = PH_FAIL;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         pos_ff   <= 4'd0;
         mark_ff  <= MK_NONE;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         mark_ff  <= mark_in;
      end
   end

endmodule

### sv/end_phrase_detector_top.sv
// Top level of the end phrase detector: front end, word queue, back end and verdict queue.
// The block takes one transcript byte per cycle while req_full is low and gives one verdict
// for each zero byte, in order; rsp_end_requested is 1 when the transcript was the closing
// phrase followed only by whitespace or the allowed punctuation marks. A zero byte passes
// through the classifying front register and the word queue, after which the back end
// pushes its verdict straight into the verdict queue, where it becomes visible. Stalls on
// the result side fill the verdict queue, then the word queue, then the front register.
module end_phrase_detector_top import epd_pkg::*; #(
   parameter int PHRASE_LENGTH = 12,
   parameter int QUEUE_DEPTH   = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_text_byte,
   output logic       req_full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_end_requested
);

   logic     fe_valid;
   word_type fe_word;
   logic     q_full;
   logic     q_empty;
   logic     q_pop;
   logic [WORD_W-1:0] q_data;
   logic     v_push;
   logic     v_data;
   logic     v_full;

   epd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_text_byte (req_text_byte),
      .req_full      (req_full),
      .fe_valid      (fe_valid),
      .fe_word       (fe_word),
      .fe_full       (q_full)
   );

   epd_fifo #(
      .WIDTH (WORD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_word_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (fe_valid),
      .wr_data (fe_word),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   epd_back #(
      .PHRASE_LENGTH (PHRASE_LENGTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_word  (word_type'(q_data)),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .v_push  (v_push),
      .v_data  (v_data),
      .v_full  (v_full)
   );

   epd_fifo #(
      .WIDTH (1),
      .DEPTH (2)
   ) u_verdict_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (v_push),
      .wr_data (v_data),
      .full    (v_full),
      .pop     (rsp_pop),
      .rd_data (rsp_end_requested),
      .empty   (rsp_empty)
   );

endmodule

### sv/epd_checker.sv
// Port level checker for the end phrase detector and its bind to the top level.
module epd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_end_requested
);

   // After reset no verdict is pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("verdict pending right after reset");

   // After reset the block takes a byte at once.
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full right after reset");

   // A waiting verdict that is not taken stays and keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_end_requested)))
      else $error("waiting verdict dropped or changed");

endmodule

bind end_phrase_detector_top epd_checker u_checker (.*);
